>>> src/lz77_triplet_decompressor_assert.svh
// Assertion macros shared by the LZ77 triplet decompressor RTL.
// Expects clk and arst_n in the scope of use.
`ifndef LZ77_TRIPLET_DECOMPRESSOR_ASSERT_SVH
`define LZ77_TRIPLET_DECOMPRESSOR_ASSERT_SVH

// property holds at every clock edge outside reset
`define LZTD_ASSERT_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies consequence in the next
`define LZTD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> src/lztd_pkg.sv
// Shared constants and types for the LZ77 triplet decompressor.
// No dependencies.
`default_nettype none

package lztd_pkg;

	localparam int LEN_W      = 4;
	localparam int DIST_W     = 12;
	localparam int BYTE_W     = 8;
	localparam int HIST_DEPTH = 4095;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);

	localparam logic [HIST_AW-1:0] HIST_LAST = HIST_AW'(HIST_DEPTH - 1);
	localparam logic [HIST_AW-1:0] HIST_FULL = HIST_AW'(HIST_DEPTH);
	localparam logic [DIST_W-1:0]  DIST_WRAP = DIST_W'(HIST_DEPTH);

	// one byte issued to the history pipeline
	typedef struct packed {
		logic               valid;
		logic               copy;
		logic               zero;
		logic               last;
		logic               bad;
		logic [BYTE_W-1:0]  lit;
		logic [HIST_AW-1:0] raddr;
		logic [HIST_AW-1:0] waddr;
	} lztd_issue_t;

endpackage

`default_nettype wire

>>> src/lztd_ram.sv
// Generic single-write, single-read synchronous RAM, read-first, registered read data.
// No dependencies.
`default_nettype none

module lztd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4095,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/lztd_seq.sv
// Triplet sequencer: takes triplets, issues one history byte per cycle while advance is high.
// Tracks write cursor and fill count. Depends on lztd_pkg and the assertion header.
`default_nettype none

`include "lz77_triplet_decompressor_assert.svh"

module lztd_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [lztd_pkg::LEN_W-1:0]  match_length,
	input  wire logic [lztd_pkg::DIST_W-1:0] match_distance,
	input  wire logic [lztd_pkg::BYTE_W-1:0] literal_byte,
	input  wire logic                        advance,
	output lztd_pkg::lztd_issue_t            issue
);

	import lztd_pkg::*;

	logic               busy_q;
	logic [LEN_W-1:0]   cnt_q;
	logic [HIST_AW-1:0] back_q;
	logic [BYTE_W-1:0]  lit_q;
	logic               bad_q;
	logic [HIST_AW-1:0] cursor_q;
	logic [HIST_AW-1:0] fill_q;

	logic               accept;
	logic               step;
	logic               last;
	logic               in_bad;
	logic [HIST_AW-1:0] in_back;
	logic [HIST_AW-1:0] src;

	assign last     = (cnt_q == '0);
	assign step     = advance && busy_q;
	assign in_stall = busy_q && !(step && last);
	assign accept   = in_valid && !in_stall;
	assign in_bad   = (match_length != '0) && (match_distance == '0);

	always_comb begin
		if (match_distance >= DIST_WRAP) begin
			in_back = HIST_AW'(match_distance - DIST_WRAP);
		end else begin
			in_back = HIST_AW'(match_distance);
		end
	end

	always_comb begin
		if (cursor_q >= back_q) begin
			src = cursor_q - back_q;
		end else begin
			src = cursor_q + (HIST_FULL - back_q);
		end
	end

	always_comb begin
		issue.valid = busy_q;
		issue.copy  = !last;
		issue.zero  = (src >= fill_q);
		issue.last  = last;
		issue.bad   = bad_q && last;
		issue.lit   = lit_q;
		issue.raddr = src;
		issue.waddr = cursor_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			cursor_q <= '0;
			fill_q   <= '0;
		end else begin
			if (step) begin
				cursor_q <= (cursor_q == HIST_LAST) ? '0 : cursor_q + 1'b1;
				if (fill_q != HIST_FULL) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= in_bad ? '0 : match_length;
			end else if (step) begin
				if (!last) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			back_q <= in_back;
			lit_q  <= literal_byte;
			bad_q  <= in_bad;
		end
	end

	`LZTD_ASSERT_HOLDS(a_cursor_range, cursor_q <= HIST_LAST, "write cursor out of range")
	`LZTD_ASSERT_HOLDS(a_fill, (fill_q == HIST_FULL) || (cursor_q == fill_q), "fill count off")
	`LZTD_ASSERT_HOLDS(a_bad_no_copy, !(busy_q && bad_q) || (cnt_q == '0), "copy on bad distance")
	`LZTD_ASSERT_NEXT(a_accept_busy, accept, busy_q, "accepted triplet not in progress")

endmodule

`default_nettype wire

>>> src/lz77_triplet_decompressor.sv
// LZ77 triplet decompressor top level: sequencer, history RAM, read stage, output register.
// Depends on lztd_pkg, lztd_seq and lztd_ram.
//
// Input channel (in_valid / in_stall) carries one triplet per transaction: match_length,
// match_distance, literal_byte. Output channel (out_valid / out_stall) carries one byte per
// transaction with last_of_item on the literal and bad_distance on the literal of a triplet
// with nonzero length and zero distance (its copy is skipped).
// A triplet yields match_length + 1 bytes (one byte when bad), at most 16, and occupies the
// sequencer until its literal issues, with one history RAM write per byte and one read per
// copied byte; the next triplet is taken in the cycle its predecessor's literal issues, so
// sustained rate is one byte per cycle while out_stall does not hold the pipe. The first byte
// of a triplet passes the issue, RAM read and output register stages after it is accepted.
// Reset clears cursor, fill count and all valids; history slots not yet written since reset
// are read as zero through the fill count, so no clearing pass is needed.
// While out_stall holds a pending byte, the whole pipe freezes (RAM reads and writes too)
// and in_stall stays high while the sequencer holds a triplet.
`default_nettype none

module lz77_triplet_decompressor (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [lztd_pkg::LEN_W-1:0]  match_length,
	input  wire logic [lztd_pkg::DIST_W-1:0] match_distance,
	input  wire logic [lztd_pkg::BYTE_W-1:0] literal_byte,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [lztd_pkg::BYTE_W-1:0] out_byte,
	output logic                             last_of_item,
	output logic                             bad_distance
);

	import lztd_pkg::*;

	lztd_issue_t        issue;
	logic               advance;
	logic               s1_valid_q;
	lztd_issue_t        issue_s1;
	logic               fwd_s1;
	logic [BYTE_W-1:0]  fwd_data_s1;
	logic [BYTE_W-1:0]  rdata;
	logic [BYTE_W-1:0]  byte_s1;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               last_q;
	logic               bad_q;

	assign advance = !out_valid_q || !out_stall;

	lztd_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.match_length   (match_length),
		.match_distance (match_distance),
		.literal_byte   (literal_byte),
		.advance        (advance),
		.issue          (issue)
	);

	lztd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (HIST_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (advance && s1_valid_q),
		.waddr (issue_s1.waddr),
		.wdata (byte_s1),
		.re    (advance && issue.valid && issue.copy),
		.raddr (issue.raddr),
		.rdata (rdata)
	);

	always_comb begin
		if (!issue_s1.copy) begin
			byte_s1 = issue_s1.lit;
		end else if (fwd_s1) begin
			byte_s1 = fwd_data_s1;
		end else if (issue_s1.zero) begin
			byte_s1 = '0;
		end else begin
			byte_s1 = rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			s1_valid_q  <= issue.valid;
			out_valid_q <= s1_valid_q;
		end
	end

	// read of the slot being written this cycle takes the new byte
	always_ff @(posedge clk) begin
		if (advance) begin
			issue_s1    <= issue;
			fwd_s1      <= s1_valid_q && (issue.raddr == issue_s1.waddr);
			fwd_data_s1 <= byte_s1;
			out_byte_q  <= byte_s1;
			last_q      <= issue_s1.last;
			bad_q       <= issue_s1.bad;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_item = last_q;
	assign bad_distance = bad_q;

endmodule

`default_nettype wire

>>> dv/lz77_triplet_decompressor_test.sv
// Testbench for lz77_triplet_decompressor: directed and random triplet streams with bursty
// input, random output stalls and a history predictor checking every output byte.
// Depends on lztd_pkg and the lz77_triplet_decompressor RTL.
`timescale 1ns / 100ps

module lz77_triplet_decompressor_test;
	import lztd_pkg::*;

	localparam int STUCK_LIMIT = 2000;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              bad;
	} emitted_byte_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [LEN_W-1:0]  match_length = '0;
	logic [DIST_W-1:0] match_distance = '0;
	logic [BYTE_W-1:0] literal_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic              last_of_item;
	logic              bad_distance;

	logic [BYTE_W-1:0] hist_mem [HIST_DEPTH] = '{default: '0};
	int                hist_cursor = 0;
	emitted_byte_t     decoded_q [$];
	int                errors = 0;
	int                burst_left = 0;
	int                stall_run = 0;
	int                stuck_cycles = 0;

	lz77_triplet_decompressor uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.match_length   (match_length),
		.match_distance (match_distance),
		.literal_byte   (literal_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.last_of_item   (last_of_item),
		.bad_distance   (bad_distance)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// expands one triplet into the bytes it yields and updates the history
	task automatic decode_triplet(input logic [LEN_W-1:0] len,
			input logic [DIST_W-1:0] distance, input logic [BYTE_W-1:0] lit);
		int            back;
		int            src;
		logic          skip;
		emitted_byte_t e;
		skip = (len != '0) && (distance == '0);
		back = int'(distance) % HIST_DEPTH;
		if (!skip) begin
			for (int i = 0; i < int'(len); i++) begin
				src = (hist_cursor + HIST_DEPTH - back) % HIST_DEPTH;
				e.data = hist_mem[src];
				e.last = 1'b0;
				e.bad = 1'b0;
				hist_mem[hist_cursor] = e.data;
				decoded_q = {decoded_q, e};
				hist_cursor = (hist_cursor + 1) % HIST_DEPTH;
			end
		end
		e.data = lit;
		e.last = 1'b1;
		e.bad = skip;
		hist_mem[hist_cursor] = lit;
		decoded_q = {decoded_q, e};
		hist_cursor = (hist_cursor + 1) % HIST_DEPTH;
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			decode_triplet(match_length, match_distance, literal_byte);
	end

	always @(posedge clk) begin
		emitted_byte_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				$error("unexpected output byte %0h", out_byte);
				errors++;
			end else begin
				e = decoded_q.pop_front();
				if (out_byte !== e.data) begin
					$error("out_byte: expected %0h, got %0h", e.data, out_byte);
					errors++;
				end
				if (last_of_item !== e.last) begin
					$error("last_of_item: expected %0b, got %0b", e.last, last_of_item);
					errors++;
				end
				if (bad_distance !== e.bad) begin
					$error("bad_distance: expected %0b, got %0b", e.bad, bad_distance);
					errors++;
				end
			end
		end
	end

	// receiver: short stall runs between free runs, some of them long
	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run--;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b1;
			stall_run = $urandom_range(0, 9);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic send_triplet(input logic [LEN_W-1:0] len,
			input logic [DIST_W-1:0] distance, input logic [BYTE_W-1:0] lit);
		in_valid <= 1'b1;
		match_length <= len;
		match_distance <= distance;
		literal_byte <= lit;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			match_length <= LEN_W'($urandom);
			match_distance <= DIST_W'($urandom);
			literal_byte <= BYTE_W'($urandom);
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 10);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (decoded_q.size() != 0);
	endtask

	// copies from slots never written since reset read zero
	task automatic test_fresh_history();
		send_triplet(4'd15, 12'd2048, 8'hFF);
		send_triplet(4'd2, 12'd4095, 8'h00);
	endtask

	task automatic test_literal_only();
		send_triplet(4'd0, 12'd0, 8'h00);
		send_triplet(4'd0, 12'd4095, 8'hFF);
		send_triplet(4'd0, 12'hA5A, 8'h81);
	endtask

	task automatic test_overlapping_copy();
		send_triplet(4'd15, 12'd1, 8'h22);
		send_triplet(4'd15, 12'd2, 8'h33);
		send_triplet(4'd15, 12'd3, 8'h44);
		send_triplet(4'd7, 12'd16, 8'h55);
	endtask

	task automatic test_bad_distance();
		send_triplet(4'd1, 12'd0, 8'h66);
		send_triplet(4'd15, 12'd0, 8'h77);
		send_triplet(4'd8, 12'd0, 8'h00);
	endtask

	task automatic test_far_distance();
		send_triplet(4'd15, 12'd4094, 8'h88);
		send_triplet(4'd15, 12'd4095, 8'h99);
		send_triplet(4'd4, 12'h800, 8'h7E);
	endtask

	// mostly long copies so the cursor wraps around the history
	task automatic test_random_stream(input int count);
		int               r;
		logic [LEN_W-1:0] len;
		logic [DIST_W-1:0] distance;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				len = 4'd15;
			else if (r < 85)
				len = LEN_W'($urandom_range(12, 14));
			else
				len = LEN_W'($urandom_range(0, 11));
			r = $urandom_range(0, 99);
			if (r < 5)
				distance = '0;
			else if (r < 10)
				distance = DIST_W'(HIST_DEPTH);
			else if (r < 15)
				distance = DIST_W'($urandom_range(4080, 4095));
			else if (r < 45)
				distance = DIST_W'($urandom_range(1, 16));
			else if (r < 60)
				distance = DIST_W'($urandom_range(17, 300));
			else
				distance = DIST_W'($urandom_range(1, 4095));
			send_triplet(len, distance, BYTE_W'($urandom_range(0, 255)));
			if (i == count / 2)
				wait_drained();
		end
	endtask

	// oldest-byte reads once the history has wrapped
	task automatic test_wrapped_history();
		send_triplet(4'd15, 12'd4095, 8'hC3);
		send_triplet(4'd15, 12'd4094, 8'h3C);
		send_triplet(4'd15, 12'd1, 8'hE7);
		send_triplet(4'd0, 12'd0, 8'hFF);
	endtask

	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		test_fresh_history();
		test_literal_only();
		test_overlapping_copy();
		wait_drained();
		test_bad_distance();
		test_far_distance();
		test_random_stream(320);
		test_wrapped_history();
		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0 && decoded_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/lztd_pkg.sv
src/lztd_ram.sv
src/lztd_seq.sv
src/lz77_triplet_decompressor.sv
dv/lz77_triplet_decompressor_test.sv
